[design/tfp_pkg.sv]
package tfp_pkg;

  // item field widths
  localparam int unsigned DialW  = 26;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ClkW   = 28;
  localparam int unsigned CarrW  = 25;
  localparam int unsigned ToneW  = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 25;

  // operating modes
  localparam logic [ModeW-1:0] OP_LSB    = 2'd0;
  localparam logic [ModeW-1:0] OP_USB    = 2'd1;
  localparam logic [ModeW-1:0] OP_CW     = 2'd2;
  localparam logic [ModeW-1:0] OP_CW_REV = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SSB_CARRIER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CW_CARRIER  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CW_TONE     = 2'd2;

  // register reset values
  localparam logic [CarrW-1:0] SSB_CARRIER_RST = 25'd11995000;
  localparam logic [CarrW-1:0] CW_CARRIER_RST  = 25'd11995000;
  localparam logic [ToneW-1:0] CW_TONE_RST     = 11'd700;

  // second oscillator for the upper and lower plans
  localparam logic [ClkW-1:0] UPPER_SECOND_OSC = 28'd56995000;
  localparam logic [ClkW-1:0] LOWER_SECOND_OSC = 28'd32995000;

  // low-pass filter thresholds
  localparam logic [DialW-1:0] LPF_A_MAX_HZ   = 26'd21000000;
  localparam logic [DialW-1:0] LPF_B_LIMIT_HZ = 26'd14000000;
  localparam logic [DialW-1:0] LPF_C_MAX_HZ   = 26'd7000000;

  // band edges in hertz (khz edge times 1000): floor(hz/1000) >= lo is
  // hz >= lo*1000, floor(hz/1000) < hi is hz < hi*1000
  localparam int unsigned BandCount = 10;
  localparam logic [DialW-1:0] BAND_LO_HZ [BandCount] = '{
    26'd1800000, 26'd3500000, 26'd5351000, 26'd7000000, 26'd10100000,
    26'd14000000, 26'd18068000, 26'd21000000, 26'd24890000, 26'd28000000
  };
  localparam logic [DialW-1:0] BAND_HI_HZ [BandCount] = '{
    26'd2000000, 26'd3900000, 26'd5367000, 26'd7200000, 26'd10150000,
    26'd14350000, 26'd18168000, 26'd21450000, 26'd24990000, 26'd29700000
  };

  typedef struct packed {
    logic in_band;
    logic lpf_a;
    logic lpf_b;
    logic lpf_c;
  } band_info_t;

endpackage

[design/tfp_band_check.sv]
module tfp_band_check (
  input  logic [tfp_pkg::DialW-1:0] dial_hz_i,
  output tfp_pkg::band_info_t       info_o
);
  import tfp_pkg::*;

  logic [BandCount-1:0] hit;

  // one compare pair per band, all in parallel
  always_comb begin
    for (int i = 0; i < BandCount; i++) begin
      hit[i] = (dial_hz_i >= BAND_LO_HZ[i]) && (dial_hz_i < BAND_HI_HZ[i]);
    end
  end

  assign info_o.in_band = |hit;
  assign info_o.lpf_a   = dial_hz_i <= LPF_A_MAX_HZ;
  assign info_o.lpf_b   = dial_hz_i <  LPF_B_LIMIT_HZ;
  assign info_o.lpf_c   = dial_hz_i <= LPF_C_MAX_HZ;

endmodule

[design/tfp_plan.sv]
module tfp_plan (
  input  logic [tfp_pkg::DialW-1:0] dial_hz_i,
  input  logic [tfp_pkg::ModeW-1:0] op_mode_i,
  input  logic                      tx_i,
  input  logic [tfp_pkg::CarrW-1:0] ssb_carrier_i,
  input  logic [tfp_pkg::CarrW-1:0] cw_carrier_i,
  input  logic [tfp_pkg::ToneW-1:0] cw_tone_i,
  output logic [tfp_pkg::ClkW-1:0]  clk0_hz_o,
  output logic [tfp_pkg::ClkW-1:0]  clk1_hz_o,
  output logic [tfp_pkg::ClkW-1:0]  clk2_hz_o
);
  import tfp_pkg::*;

  logic            cw_kind;
  logic            upper;
  logic [ClkW-1:0] carrier;
  logic [ClkW-1:0] dial;
  logic [ClkW-1:0] tone;
  logic [ClkW-1:0] base;
  logic [ClkW-1:0] shift;

  assign cw_kind = (op_mode_i == OP_CW) || (op_mode_i == OP_CW_REV);
  assign upper   = (op_mode_i == OP_USB) || (op_mode_i == OP_CW);
  assign carrier = {{(ClkW-CarrW){1'b0}}, cw_kind ? cw_carrier_i : ssb_carrier_i};
  assign dial    = {{(ClkW-DialW){1'b0}}, dial_hz_i};
  assign tone    = {{(ClkW-ToneW){1'b0}}, cw_tone_i};

  // upper plan subtracts the carrier, lower plan adds it
  assign base = upper ? (UPPER_SECOND_OSC - carrier) : (LOWER_SECOND_OSC + carrier);

  // receive pitch offset; modulo 2^28 arithmetic, the final sum is always in range
  always_comb begin
    shift = '0;
    if (!tx_i) begin
      case (op_mode_i)
        OP_CW:     shift = ClkW'(~tone + 1'b1);
        OP_CW_REV: shift = tone;
        default:   shift = '0;
      endcase
    end
  end

  always_comb begin
    clk0_hz_o = carrier;
    if (tx_i && cw_kind) begin
      clk1_hz_o = '0;
      clk2_hz_o = dial;
    end else begin
      clk1_hz_o = upper ? UPPER_SECOND_OSC : LOWER_SECOND_OSC;
      clk2_hz_o = base + dial + shift;
    end
  end

endmodule

[design/transceiver_frequency_plan.sv]
// frequency plan for a dual-conversion superhet transceiver
//
// command channel: an item (dial_hz_i, op_mode_i, tx_request_i) is taken at
// a rising edge where start_i is high and busy_o is low. busy_o stays low, so
// a new item can be started in every cycle.
// result channel: done_o is high for exactly one cycle with the three
// synthesizer frequencies, the filter relay bits and the transmit status.
// pipeline: an accepted item passes the input register, then the result
// register, which raises done_o with the result; throughput is one item
// per cycle, set by the single combinational pass between the two
// registers.
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 ssb carrier, 1 cw carrier, 2 cw tone); index 3 is ignored. write only
// while no item is in flight.
// reset: rst_ni clears the pipeline valid bits and loads the register reset
// values; no result is lost or repeated since the receiver cannot stall.
module transceiver_frequency_plan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [tfp_pkg::DialW-1:0]    dial_hz_i,
  input  logic [tfp_pkg::ModeW-1:0]    op_mode_i,
  input  logic                         tx_request_i,
  input  logic                         cfg_we_i,
  input  logic [tfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tfp_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         done_o,
  output logic [tfp_pkg::ClkW-1:0]     clk0_hz_o,
  output logic [tfp_pkg::ClkW-1:0]     clk1_hz_o,
  output logic [tfp_pkg::ClkW-1:0]     clk2_hz_o,
  output logic                         lpf_a_o,
  output logic                         lpf_b_o,
  output logic                         lpf_c_o,
  output logic                         tx_active_o,
  output logic                         tx_refused_o
);
  import tfp_pkg::*;

  // configuration registers
  logic [CarrW-1:0] ssb_carrier_q;
  logic [CarrW-1:0] cw_carrier_q;
  logic [ToneW-1:0] cw_tone_q;

  // input stage
  logic             in_valid_q;
  logic [DialW-1:0] dial_q;
  logic [ModeW-1:0] mode_q;
  logic             tx_req_q;

  // result stage
  logic             done_q;
  logic [ClkW-1:0]  clk0_q, clk1_q, clk2_q;
  logic             lpf_a_q, lpf_b_q, lpf_c_q;
  logic             tx_active_q, tx_refused_q;

  logic             accept;
  band_info_t       band;
  logic             tx;
  logic [ClkW-1:0]  clk0_d, clk1_d, clk2_d;

  // fully pipelined, never holds off a command
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssb_carrier_q <= SSB_CARRIER_RST;
      cw_carrier_q  <= CW_CARRIER_RST;
      cw_tone_q     <= CW_TONE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SSB_CARRIER: ssb_carrier_q <= cfg_data_i;
        CFG_CW_CARRIER:  cw_carrier_q  <= cfg_data_i;
        CFG_CW_TONE:     cw_tone_q     <= cfg_data_i[ToneW-1:0];
        default: ; // unused index
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= accept;
      done_q     <= in_valid_q;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dial_q   <= dial_hz_i;
      mode_q   <= op_mode_i;
      tx_req_q <= tx_request_i;
    end
  end

  // band membership and filter relays
  tfp_band_check u_band (
    .dial_hz_i (dial_q),
    .info_o    (band)
  );

  // transmit only inside a band
  assign tx = tx_req_q && band.in_band;

  tfp_plan u_plan (
    .dial_hz_i     (dial_q),
    .op_mode_i     (mode_q),
    .tx_i          (tx),
    .ssb_carrier_i (ssb_carrier_q),
    .cw_carrier_i  (cw_carrier_q),
    .cw_tone_i     (cw_tone_q),
    .clk0_hz_o     (clk0_d),
    .clk1_hz_o     (clk1_d),
    .clk2_hz_o     (clk2_d)
  );

  // result payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      clk0_q       <= clk0_d;
      clk1_q       <= clk1_d;
      clk2_q       <= clk2_d;
      lpf_a_q      <= band.lpf_a;
      lpf_b_q      <= band.lpf_b;
      lpf_c_q      <= band.lpf_c;
      tx_active_q  <= tx;
      tx_refused_q <= tx_req_q && !band.in_band;
    end
  end

  assign done_o       = done_q;
  assign clk0_hz_o    = clk0_q;
  assign clk1_hz_o    = clk1_q;
  assign clk2_hz_o    = clk2_q;
  assign lpf_a_o      = lpf_a_q;
  assign lpf_b_o      = lpf_b_q;
  assign lpf_c_o      = lpf_c_q;
  assign tx_active_o  = tx_active_q;
  assign tx_refused_o = tx_refused_q;

endmodule
